/* rtl/core/lcr_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lcr_pkg: shared constants and types of the load-cell reader
// widths, request codes, reset values and the sequencer state type
// ----------------------------------------------------------------------------
package lcr_pkg;

    localparam int DATA_BITS_DEF = 24;
    localparam int OUT_W         = 24;
    localparam int GAP_W         = 16;

    localparam logic [GAP_W-1:0] GAP_RESET = 16'd104;

    localparam int FUNC_W = 2;
    localparam logic [FUNC_W-1:0] FUNC_TARE  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_WEIGH = 2'd2;

    // stream widths, whole bytes
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 56;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_DIV
    } lcr_state_t;

endpackage : lcr_pkg
`default_nettype wire

/* rtl/core/lcr_divider.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lcr_divider: bit-serial restoring divider
// one quotient bit per cycle, dividend shifted in msb first
// ----------------------------------------------------------------------------
module lcr_divider #(
    parameter int DATA_BITS = lcr_pkg::DATA_BITS_DEF
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          start,
    input  wire [DATA_BITS-1:0]          dividend,
    input  wire [lcr_pkg::GAP_W-1:0]     divisor,
    output logic                         done,
    output logic [DATA_BITS-1:0]         quotient
);
    import lcr_pkg::*;

    localparam int CNT_W = $clog2(DATA_BITS + 1);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [GAP_W-1:0]     rem_reg, rem_next;
    logic [DATA_BITS-1:0] quo_reg, quo_next;

    logic [GAP_W:0]       trial;
    logic [GAP_W:0]       trial_sub;
    logic                 fits;

    assign trial     = {rem_reg, quo_reg[DATA_BITS-1]};
    assign trial_sub = trial - {1'b0, divisor};
    assign fits      = (trial >= {1'b0, divisor});

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DATA_BITS);
            rem_next  = '0;
            quo_next  = dividend;
        end else if (busy_reg) begin
            rem_next = fits ? trial_sub[GAP_W-1:0] : trial[GAP_W-1:0];
            quo_next = {quo_reg[DATA_BITS-2:0], fits};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule : lcr_divider
`default_nettype wire

/* rtl/core/load_cell_adc_reader_with_tare_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// load_cell_adc_reader_with_tare_core: two-wire load-cell reader with tare
// tick-driven serial read of the converter, tare capture and scaled weight
// ----------------------------------------------------------------------------
//  channel   direction  handshake            contents
//  s_        in         s_tvalid/s_tready    one tick: request code, data line
//  m_        out        m_tvalid/m_tready    one result per tick
//  cfg_      in         cfg_valid/cfg_ready  gap register write (16 bits)
//
//  an ordinary tick's result is written to the output register; the tick that
//  completes a weigh read first runs the bit-serial divider; the data word is
//  gathered one bit per sck pulse in a shift register; the result sits in an
//  output register, so, with no division running, the next tick is taken in
//  the cycle its predecessor's result leaves or while the register is empty
//  reset (aresetn low, synchronous) clears the sequencer, tare, weight and
//  sets the gap register to 104
// ----------------------------------------------------------------------------
module load_cell_adc_reader_with_tare_core #(
    parameter int DATA_BITS = lcr_pkg::DATA_BITS_DEF
) (
    input  wire                            aclk,
    input  wire                            aresetn,
    // [1:0] func, [2] dout, [7:3] zero
    input  wire [lcr_pkg::S_TDATA_W-1:0]   s_tdata,
    input  wire                            s_tvalid,
    output logic                           s_tready,
    // [0] sck, [1] busy_res, [2] done_res, [26:3] raw_value,
    // [50:27] net_weight, [55:51] zero
    output logic [lcr_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic                           m_tvalid,
    input  wire                            m_tready,
    // gap_value write
    input  wire [lcr_pkg::GAP_W-1:0]       cfg_data,
    input  wire                            cfg_valid,
    output logic                           cfg_ready
);
    import lcr_pkg::*;

    localparam int LAST_PHASE = 2 * DATA_BITS + 1;
    localparam int PH_W       = $clog2(2 * DATA_BITS + 2);
    localparam logic [DATA_BITS-1:0] TOP_BIT = {1'b1, {(DATA_BITS-1){1'b0}}};

    // sequencer and read state
    lcr_state_t           state_reg, state_next;
    logic [PH_W-1:0]      phase_reg, phase_next;
    logic                 waiting_reg, waiting_next;
    logic [DATA_BITS-1:0] shift_reg, shift_next;
    logic                 tare_rd_reg, tare_rd_next;
    logic [DATA_BITS-1:0] tare_reg, tare_next;
    logic [OUT_W-1:0]     weight_reg, weight_next;
    logic [OUT_W-1:0]     raw_reg, raw_next;
    logic                 sck_reg, sck_next;
    logic [GAP_W-1:0]     gap_reg;

    // output register
    logic                 m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0] m_data_reg, m_data_next;

    logic [FUNC_W-1:0]    func;
    logic                 dout;
    logic                 in_xfer;
    logic                 out_free;

    logic [DATA_BITS-1:0] raw_full;
    logic [DATA_BITS:0]   diff;
    logic                 div_start;
    logic                 div_done;
    logic [DATA_BITS-1:0] div_quot;
    logic [OUT_W-1:0]     weight_sat;
    logic                 busy_now;

    assign func = s_tdata[FUNC_W-1:0];
    assign dout = s_tdata[FUNC_W];

    assign out_free  = !m_valid_reg || m_tready;
    assign s_tready  = (state_reg == ST_IDLE) && out_free;
    assign in_xfer   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // flip the sign bit: two's complement reading to offset binary
    assign raw_full = shift_reg ^ TOP_BIT;
    // one subtractor gives both the compare and the dividend
    assign diff     = {1'b0, raw_full} - {1'b0, tare_reg};

    // quotients beyond the result field saturate
    assign weight_sat = ((div_quot >> OUT_W) != '0) ? {OUT_W{1'b1}} : OUT_W'(div_quot);

    assign busy_now = waiting_reg || (phase_reg != '0);

    lcr_divider #(
        .DATA_BITS (DATA_BITS)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (diff[DATA_BITS-1:0]),
        .divisor  (gap_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    always_comb begin
        logic finish;
        logic done_tick;
        logic busy_step;

        state_next   = state_reg;
        phase_next   = phase_reg;
        waiting_next = waiting_reg;
        shift_next   = shift_reg;
        tare_rd_next = tare_rd_reg;
        tare_next    = tare_reg;
        weight_next  = weight_reg;
        raw_next     = raw_reg;
        sck_next     = sck_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        div_start    = 1'b0;
        finish       = 1'b0;
        done_tick    = 1'b0;
        busy_step    = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    if (waiting_reg) begin
                        // converter ready once the data line goes low
                        if (!dout) begin
                            waiting_next = 1'b0;
                            sck_next     = 1'b1;
                            phase_next   = PH_W'(1);
                        end
                    end else if (phase_reg != '0) begin
                        if (phase_reg[0]) begin
                            // clock high: drive it low
                            sck_next = 1'b0;
                            if (phase_reg >= PH_W'(LAST_PHASE)) begin
                                phase_next = '0;
                                finish     = 1'b1;
                            end else begin
                                phase_next = phase_reg + PH_W'(1);
                            end
                        end else begin
                            // after a falling edge: take a bit, raise next pulse
                            shift_next = {shift_reg[DATA_BITS-2:0], dout};
                            sck_next   = 1'b1;
                            phase_next = phase_reg + PH_W'(1);
                        end
                    end else if (func == FUNC_TARE || func == FUNC_WEIGH) begin
                        tare_rd_next = (func == FUNC_TARE);
                        waiting_next = 1'b1;
                        shift_next   = '0;
                        sck_next     = 1'b0;
                    end

                    if (finish) begin
                        done_tick = 1'b1;
                        raw_next  = OUT_W'(raw_full);
                        if (tare_rd_reg) begin
                            tare_next = raw_full;
                        end else if (diff[DATA_BITS]) begin
                            weight_next = '0;
                        end else if (gap_reg == '0) begin
                            weight_next = {OUT_W{1'b1}};
                        end else begin
                            div_start  = 1'b1;
                            state_next = ST_DIV;
                        end
                    end

                    busy_step = waiting_next || (phase_next != '0);
                    if (!div_start) begin
                        m_valid_next = 1'b1;
                        m_data_next  = M_TDATA_W'({weight_next, raw_next, done_tick,
                                                   busy_step, sck_next});
                    end
                end
            end
            ST_DIV: begin
                // completion tick of a weigh read waits for the quotient
                if (div_done) begin
                    weight_next  = weight_sat;
                    m_valid_next = 1'b1;
                    m_data_next  = M_TDATA_W'({weight_sat, raw_reg, 1'b1,
                                               busy_now, sck_reg});
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            phase_reg   <= '0;
            waiting_reg <= 1'b0;
            shift_reg   <= '0;
            tare_rd_reg <= 1'b0;
            tare_reg    <= '0;
            weight_reg  <= '0;
            raw_reg     <= '0;
            sck_reg     <= 1'b0;
            gap_reg     <= GAP_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            waiting_reg <= waiting_next;
            shift_reg   <= shift_next;
            tare_rd_reg <= tare_rd_next;
            tare_reg    <= tare_next;
            weight_reg  <= weight_next;
            raw_reg     <= raw_next;
            sck_reg     <= sck_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                gap_reg <= cfg_data;
            end
        end
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule : load_cell_adc_reader_with_tare_core
`default_nettype wire
